[hw/rtl/gregorian_date_arithmetic_assert.svh]
// Assertion macros for the date arithmetic block.
// Included by the RTL modules that carry assertions; no other dependencies.
`ifndef GREGORIAN_DATE_ARITHMETIC_ASSERT_SVH
`define GREGORIAN_DATE_ARITHMETIC_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication, held off during reset.
`define GDA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("date arithmetic: assertion failed");

// Next-cycle implication, held off during reset.
`define GDA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("date arithmetic: assertion failed");

`else

`define GDA_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define GDA_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[hw/rtl/gda_pkg.sv]
// Package for the date arithmetic block: operation codes, field widths and
// calendar helper functions (leap test, month length, days before a month).
`default_nettype none

package gda_pkg;

  localparam int unsigned DayInW  = 6;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned YearW   = 14;
  localparam int unsigned DayOutW = 5;
  localparam int unsigned OrdW    = 9;

  typedef enum logic [1:0] {
    OP_VALIDATE = 2'd0,
    OP_ORDINAL  = 2'd1,
    OP_NEXT     = 2'd2,
    OP_PREV     = 2'd3
  } op_e;

  // Divisibility by 25 via the modular inverse of 25 mod 2^14:
  // y % 25 == 0  <=>  (y * Inv25) mod 2^14 <= floor((2^14 - 1) / 25)
  localparam logic [YearW-1:0] Inv25   = 14'd7209;
  localparam logic [YearW-1:0] Div25Lim = 14'd655;

  // 4/100/400 rule: y%4==0 and (y%25!=0 or y%16==0)
  function automatic logic is_leap(input logic [YearW-1:0] year);
    logic [2*YearW-1:0] full;
    logic               div25;
    full  = (2*YearW)'(year) * (2*YearW)'(Inv25);
    div25 = (full[YearW-1:0] <= Div25Lim);
    return (year[1:0] == 2'b00) && (!div25 || (year[3:0] == 4'd0));
  endfunction

  // Length of a month; 0 for month numbers outside 1..12.
  function automatic logic [DayOutW-1:0] days_in_month(input logic [MonthW-1:0] month,
                                                        input logic leap);
    logic [DayOutW-1:0] len;
    unique case (month) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // Days in a common year before the first of the given month.
  function automatic logic [OrdW-1:0] days_before(input logic [MonthW-1:0] month);
    logic [OrdW-1:0] n;
    unique case (month)
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/gregorian_date_arithmetic.sv]
// Gregorian date arithmetic: validate, day of year, next day, previous day.
// An accepted item is held in the input register, then passes the calendar logic
// into the result register when that register advances. Throughput: one item per
// cycle while the receiver does not stall, set by the single registered calendar pass.
// Reset (rst_ni, async, active low) empties both stages; there is no other state.
`default_nettype none

`include "gregorian_date_arithmetic_assert.svh"

module gregorian_date_arithmetic (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // input channel
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [1:0]                       operation_i,
  input  wire logic [gda_pkg::DayInW-1:0]       day_in_i,
  input  wire logic [gda_pkg::MonthW-1:0]       month_in_i,
  input  wire logic [gda_pkg::YearW-1:0]        year_in_i,
  // result channel
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic                                  date_valid_o,
  output logic [gda_pkg::DayOutW-1:0]           day_out_o,
  output logic [gda_pkg::MonthW-1:0]            month_out_o,
  output logic [gda_pkg::YearW-1:0]             year_out_o,
  output logic [gda_pkg::OrdW-1:0]              ordinal_day_o
);

  // ---------------------------------------------------------------------------
  // Handshake. The result register advances when it is empty or being taken;
  // the input register then moves into it. The input side only stalls when
  // the input register is full and cannot move on, so an item is still taken
  // while a finished result waits downstream.
  // ---------------------------------------------------------------------------
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;
  logic out_adv;
  logic in_acc;

  assign out_adv    = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !out_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign s1_valid_d  = in_acc ? 1'b1 : (out_adv ? 1'b0 : s1_valid_q);
  assign out_valid_d = out_adv ? s1_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Input register (payload, no reset)
  // ---------------------------------------------------------------------------
  gda_pkg::op_e                  op_q;
  logic [gda_pkg::DayInW-1:0]    day_q;
  logic [gda_pkg::MonthW-1:0]    mon_q;
  logic [gda_pkg::YearW-1:0]     yr_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q  <= gda_pkg::op_e'(operation_i);
      day_q <= day_in_i;
      mon_q <= month_in_i;
      yr_q  <= year_in_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Calendar logic. The leap test uses a constant-multiply divisibility check
  // by 25 plus masks for 4 and 16. The previous-day rollover reuses the leap
  // flag of the input year: the year only changes when stepping back to
  // December, which is 31 days regardless.
  // ---------------------------------------------------------------------------
  logic                          leap;
  logic [gda_pkg::DayOutW-1:0]   dim;
  logic                          ok;
  logic                          last_day;
  logic [gda_pkg::MonthW-1:0]    prev_mon;
  logic [gda_pkg::DayOutW-1:0]   day_inc;

  logic                          date_valid_d;
  logic [gda_pkg::DayOutW-1:0]   day_out_d;
  logic [gda_pkg::MonthW-1:0]    month_out_d;
  logic [gda_pkg::YearW-1:0]     year_out_d;
  logic [gda_pkg::OrdW-1:0]      ordinal_d;

  assign leap     = gda_pkg::is_leap(yr_q);
  assign dim      = gda_pkg::days_in_month(mon_q, leap);
  assign ok       = (yr_q != '0) && (mon_q >= 4'd1) && (mon_q <= 4'd12) &&
                    (day_q != '0) && (day_q <= gda_pkg::DayInW'(dim));
  assign last_day = (day_q == gda_pkg::DayInW'(dim));
  assign prev_mon = (mon_q == 4'd1) ? 4'd12 : mon_q - 4'd1;
  assign day_inc  = day_q[gda_pkg::DayOutW-1:0] + 5'd1;

  always_comb begin
    date_valid_d = ok;
    day_out_d    = '0;
    month_out_d  = '0;
    year_out_d   = '0;
    ordinal_d    = '0;
    if (ok) begin
      case (op_q)
        gda_pkg::OP_ORDINAL: begin
          ordinal_d = gda_pkg::days_before(mon_q)
                    + gda_pkg::OrdW'(day_q)
                    + gda_pkg::OrdW'(leap && (mon_q > 4'd2));
        end
        gda_pkg::OP_NEXT: begin
          if (last_day) begin
            day_out_d   = 5'd1;
            month_out_d = (mon_q == 4'd12) ? 4'd1 : mon_q + 4'd1;
            year_out_d  = (mon_q == 4'd12) ? yr_q + 14'd1 : yr_q;
          end else begin
            day_out_d   = day_inc;
            month_out_d = mon_q;
            year_out_d  = yr_q;
          end
        end
        gda_pkg::OP_PREV: begin
          if (day_q == 6'd1) begin
            month_out_d = prev_mon;
            year_out_d  = (mon_q == 4'd1) ? yr_q - 14'd1 : yr_q;
            day_out_d   = gda_pkg::days_in_month(prev_mon, leap);
          end else begin
            day_out_d   = day_q[gda_pkg::DayOutW-1:0] - 5'd1;
            month_out_d = mon_q;
            year_out_d  = yr_q;
          end
        end
        default: begin
          // validate only: fields stay zero
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Result register (payload, no reset)
  // ---------------------------------------------------------------------------
  logic                          date_valid_q;
  logic [gda_pkg::DayOutW-1:0]   day_out_q;
  logic [gda_pkg::MonthW-1:0]    month_out_q;
  logic [gda_pkg::YearW-1:0]     year_out_q;
  logic [gda_pkg::OrdW-1:0]      ordinal_q;

  always_ff @(posedge clk_i) begin
    if (out_adv && s1_valid_q) begin
      date_valid_q <= date_valid_d;
      day_out_q    <= day_out_d;
      month_out_q  <= month_out_d;
      year_out_q   <= year_out_d;
      ordinal_q    <= ordinal_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign date_valid_o  = date_valid_q;
  assign day_out_o     = day_out_q;
  assign month_out_o   = month_out_q;
  assign year_out_o    = year_out_q;
  assign ordinal_day_o = ordinal_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `GDA_ASSERT_IMPL(a_invalid_zero, clk_i, rst_ni, out_valid_q && !date_valid_q,
    (day_out_q == '0) && (month_out_q == '0) && (year_out_q == '0) && (ordinal_q == '0))
  `GDA_ASSERT_IMPL(a_ord_range, clk_i, rst_ni, out_valid_q, ordinal_q <= 9'd366)
  `GDA_ASSERT_IMPL(a_day_month, clk_i, rst_ni, out_valid_q && (day_out_q != '0),
    (month_out_q >= 4'd1) && (month_out_q <= 4'd12))
  `GDA_ASSERT_IMPL(a_stall_full, clk_i, rst_ni, in_stall_o, s1_valid_q && out_valid_q)
  `GDA_ASSERT_NEXT(a_move, clk_i, rst_ni, s1_valid_q && out_adv, out_valid_q)

endmodule

`default_nettype wire

[bench/gda_checker.sv]
// Result checker for the date arithmetic block: watches both channels, predicts
// each accepted item and compares every result, field by field, in order.
// Depends on gda_pkg for the operation codes and field widths.
module gda_checker
  import gda_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [1:0]         operation_i,
  input  logic [DayInW-1:0]  day_in_i,
  input  logic [MonthW-1:0]  month_in_i,
  input  logic [YearW-1:0]   year_in_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic               date_valid_i,
  input  logic [DayOutW-1:0] day_out_i,
  input  logic [MonthW-1:0]  month_out_i,
  input  logic [YearW-1:0]   year_out_i,
  input  logic [OrdW-1:0]    ordinal_day_i,
  output int unsigned        pending_o,
  output int unsigned        error_count_o
);

  typedef struct {
    logic               date_valid;
    logic [DayOutW-1:0] day;
    logic [MonthW-1:0]  month;
    logic [YearW-1:0]   year;
    logic [OrdW-1:0]    ordinal;
  } date_result_t;

  date_result_t expected_dates[$];
  int unsigned  errors = 0;

  assign error_count_o = errors;

  task automatic report_mismatch(input string msg);
    $display("gda_checker: %0t: %s", $time, msg);
    errors++;
  endtask

  function automatic logic leap_year(input int unsigned y);
    return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
  endfunction

  // only meaningful for months 1..12
  function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
    case (m)
      2:             return leap_year(y) ? 29 : 28;
      4, 6, 9, 11:   return 30;
      default:       return 31;
    endcase
  endfunction

  function automatic date_result_t calendar_result(input op_e op, input int unsigned d,
                                                   input int unsigned m,
                                                   input int unsigned y);
    date_result_t r;
    int unsigned  rd, rm, ry, ord;
    logic         ok;
    rd  = 0;
    rm  = 0;
    ry  = 0;
    ord = 0;
    ok  = (y >= 1) && (m >= 1) && (m <= 12) && (d >= 1);
    if (ok && d > month_days(m, y)) ok = 1'b0;
    if (ok) begin
      case (op)
        OP_ORDINAL: begin
          ord = d;
          for (int unsigned i = 1; i < m; i++) ord += month_days(i, y);
        end
        OP_NEXT: begin
          rd = d + 1;
          rm = m;
          ry = y;
          if (d == month_days(m, y)) begin
            rd = 1;
            if (m == 12) begin
              rm = 1;
              ry = y + 1;
            end else begin
              rm = m + 1;
            end
          end
        end
        OP_PREV: begin
          rd = d - 1;
          rm = m;
          ry = y;
          if (d == 1) begin
            if (m == 1) begin
              rm = 12;
              ry = y - 1;   // 1 Jan of year 1 steps back into year 0
            end else begin
              rm = m - 1;
            end
            rd = month_days(rm, ry);
          end
        end
        default: ;
      endcase
    end
    r.date_valid = ok;
    r.day        = DayOutW'(rd);
    r.month      = MonthW'(rm);
    r.year       = YearW'(ry);     // wraps past the top of the field
    r.ordinal    = OrdW'(ord);
    return r;
  endfunction

  always @(posedge clk_i) begin : watch
    date_result_t want;
    if (rst_ni) begin
      // push first so that an item and its own result on one edge still pair up
      if (in_valid_i && !in_stall_i)
        expected_dates.push_back(calendar_result(op_e'(operation_i), day_in_i,
                                                 month_in_i, year_in_i));
      if (out_valid_i && !out_stall_i) begin
        if (expected_dates.size() == 0) begin
          report_mismatch("result item with nothing pending");
        end else begin
          want = expected_dates.pop_front();
          if (date_valid_i !== want.date_valid)
            report_mismatch($sformatf("date_valid got %0d want %0d",
                                      date_valid_i, want.date_valid));
          if (day_out_i !== want.day)
            report_mismatch($sformatf("day_out got %0d want %0d", day_out_i, want.day));
          if (month_out_i !== want.month)
            report_mismatch($sformatf("month_out got %0d want %0d",
                                      month_out_i, want.month));
          if (year_out_i !== want.year)
            report_mismatch($sformatf("year_out got %0d want %0d",
                                      year_out_i, want.year));
          if (ordinal_day_i !== want.ordinal)
            report_mismatch($sformatf("ordinal_day got %0d want %0d",
                                      ordinal_day_i, want.ordinal));
        end
      end
      pending_o <= expected_dates.size();
    end
  end

  initial pending_o = 0;

endmodule

[bench/tb_top.sv]
// Top of the date arithmetic bench: clock, reset, item stimulus and the verdict.
// Depends on gda_pkg, the gregorian_date_arithmetic block and gda_checker.
module tb_top;
  import gda_pkg::*;

  // long receiver hold-off, in cycles, to fill the pipe and back-pressure the input
  localparam int unsigned HoldCycles   = 80;
  localparam int unsigned RandomItems  = 400;
  // drain allowance after the last expected result
  localparam int unsigned DrainCycles  = 8;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  op_e                in_op;
  logic [DayInW-1:0]  in_day;
  logic [MonthW-1:0]  in_month;
  logic [YearW-1:0]   in_year;
  logic               out_valid;
  logic               out_stall;
  logic               res_valid;
  logic [DayOutW-1:0] res_day;
  logic [MonthW-1:0]  res_month;
  logic [YearW-1:0]   res_year;
  logic [OrdW-1:0]    res_ordinal;
  int unsigned        pending;
  int unsigned        errors;

  // sender burst bookkeeping and the hold-off request to the receiver
  int unsigned        burst_left = 0;
  logic               squeeze_req = 1'b0;

  // years around the leap rule's turning points, plus the ends of the range
  int unsigned        turn_years[$] = '{1, 4, 100, 400, 1600, 1900, 2000, 2100, 9600,
                                        9999};

  always #1 clk = ~clk;

  gregorian_date_arithmetic DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .operation_i   (in_op),
    .day_in_i      (in_day),
    .month_in_i    (in_month),
    .year_in_i     (in_year),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .date_valid_o  (res_valid),
    .day_out_o     (res_day),
    .month_out_o   (res_month),
    .year_out_o    (res_year),
    .ordinal_day_o (res_ordinal)
  );

  gda_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .operation_i   (in_op),
    .day_in_i      (in_day),
    .month_in_i    (in_month),
    .year_in_i     (in_year),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .date_valid_i  (res_valid),
    .day_out_i     (res_day),
    .month_out_i   (res_month),
    .year_out_i    (res_year),
    .ordinal_day_i (res_ordinal),
    .pending_o     (pending),
    .error_count_o (errors)
  );

  // Offer one item. Called at a falling edge; returns at the falling edge after
  // the item was taken. Between bursts valid may drop for a random gap. Fields are
  // only touched here, so a stalled item holds still until accepted.
  task automatic offer_date(input op_e op, input int unsigned d, input int unsigned m,
                            input int unsigned y);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      // now and then a long burst, so some stretches run with no sender idling
      burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_op    <= op;
    in_day   <= DayInW'(d);
    in_month <= MonthW'(m);
    in_year  <= YearW'(y);
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Receiver: segments of random length, each with its own stall density
  // (none, light, heavy). Once asked, it holds off for HoldCycles straight.
  initial begin : receiver
    int unsigned seg_len;
    int unsigned density;
    logic        held;
    held      = 1'b0;
    out_stall = 1'b0;
    forever begin
      if (squeeze_req && !held) begin
        held = 1'b1;
        repeat (HoldCycles) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
      end
      seg_len = $urandom_range(8, 48);
      density = $urandom_range(0, 2);
      repeat (seg_len) begin
        @(negedge clk);
        case (density)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Stimulus and verdict.
  initial begin : stimulus
    op_e         op;
    int unsigned d, m, y, pick;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_op    = OP_VALIDATE;
    in_day   = '0;
    in_month = '0;
    in_year  = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: leap rule at 4/100/400, month and year rollover both ways,
    // year 0 below the first day, year past the top, invalid fields of each kind.
    offer_date(OP_VALIDATE, 29, 2, 2000);   // leap by the 400 rule
    offer_date(OP_VALIDATE, 29, 2, 1900);   // century, not leap
    offer_date(OP_NEXT,     28, 2, 1900);   // rolls into March
    offer_date(OP_NEXT,     29, 2, 2024);
    offer_date(OP_PREV,      1, 3, 2024);   // back onto 29 Feb
    offer_date(OP_PREV,      1, 3, 2023);   // back onto 28 Feb
    offer_date(OP_ORDINAL,  31, 12, 2024);  // 366
    offer_date(OP_ORDINAL,  31, 12, 2023);  // 365
    offer_date(OP_ORDINAL,   1, 1, 1);
    offer_date(OP_ORDINAL,  15, 7, 2000);
    offer_date(OP_PREV,      1, 1, 1);      // 31 Dec of year 0
    offer_date(OP_PREV,      1, 1, 2000);
    offer_date(OP_NEXT,     30, 4, 2021);
    offer_date(OP_PREV,     15, 6, 2021);
    offer_date(OP_NEXT,     31, 12, 9999);  // year steps past the input range
    offer_date(OP_NEXT,     31, 12, 16383); // year wraps to 0
    offer_date(OP_NEXT,      1, 1, 0);      // year 0 is invalid
    offer_date(OP_ORDINAL,  10, 0, 2020);   // month 0
    offer_date(OP_PREV,     10, 13, 2020);
    offer_date(OP_NEXT,     10, 15, 8192);
    offer_date(OP_VALIDATE,  0, 5, 2020);   // day 0
    offer_date(OP_ORDINAL,  63, 12, 2020);  // day field all ones
    offer_date(OP_NEXT,     32, 1, 2020);
    offer_date(OP_PREV,     31, 4, 2020);   // past a 30-day month

    // Random: mostly well-formed dates with days piled at the first and at month ends, the
    // rest noise over the full day and month fields and years 0..9999. The long hold-off starts here.
    squeeze_req = 1'b1;
    for (int unsigned n = 0; n < RandomItems; n++) begin
      op   = op_e'($urandom_range(0, 3));
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        y = ($urandom_range(0, 3) == 0) ? turn_years[$urandom_range(0, 9)]
                                        : $urandom_range(1, 9999);
        m = $urandom_range(1, 12);
        case ($urandom_range(0, 3))
          0:       d = 1;
          1:       d = $urandom_range(28, 31);
          default: d = $urandom_range(1, 28);
        endcase
      end else begin
        d = $urandom_range(0, 63);
        m = $urandom_range(0, 15);
        y = $urandom_range(0, 9999);
      end
      offer_date(op, d, m, y);
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // Run limit: far beyond the slowest legal run.
  initial begin : watchdog
    #200000;
    $display("tb_top: errors");
    $finish;
  end

endmodule

[gregorian_date_arithmetic.f]
+incdir+hw/rtl
hw/rtl/gda_pkg.sv
hw/rtl/gregorian_date_arithmetic.sv
bench/gda_checker.sv
bench/tb_top.sv
